// ===== src/fqr_pkg.sv =====
// Shared constants and control types for the process-id queue.
package fqr_pkg;

  localparam int OP_BITS  = 2;
  localparam int PID_BITS = 8;
  localparam int ST_BITS  = 2;
  localparam int CNT_BITS = 5;

  localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

  localparam logic [ST_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [ST_BITS-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_BITS-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_BITS-1:0] ST_FULL      = 2'd3;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic capture;  // latch per-cell match against the incoming key
    logic commit;   // apply the operation to the stored ids
    logic insert;
    logic remove;
  } cell_ctl_t;

endpackage

// ===== src/fqr_if.sv =====
// Request and response channel interfaces for the process-id queue.
interface fqr_req_if;
  import fqr_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_BITS-1:0]  opcode;
  logic [PID_BITS-1:0] process_id;

  modport source(output valid, output opcode, output process_id, input ready);
  modport sink(input valid, input opcode, input process_id, output ready);
endinterface

interface fqr_rsp_if;
  import fqr_pkg::*;
  logic                valid;
  logic                ready;
  logic [ST_BITS-1:0]  status;
  logic [CNT_BITS-1:0] entry_count;
  logic                queue_empty;
  logic [PID_BITS-1:0] head_id;

  modport source(output valid, output status, output entry_count,
                 output queue_empty, output head_id, input ready);
  modport sink(input valid, input status, input entry_count,
               input queue_empty, input head_id, output ready);
endinterface

// ===== src/fqr_cell.sv =====
// One queue slot: stored id, match flag and shift-left on remove.
module fqr_cell import fqr_pkg::*; #(
  parameter int ID_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  cell_ctl_t          ctl,
  input  logic [ID_BITS-1:0] key,
  input  logic               occupied,
  input  logic               at_tail,
  input  logic               found,
  input  logic [ID_BITS-1:0] nbr_id,
  input  logic               hit_in,
  output logic               hit_out,
  output logic [ID_BITS-1:0] id
);

  logic hit;

  // hit_out is set from the first matching cell toward the tail
  assign hit_out = hit_in | hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.capture) begin
      hit <= occupied && (id == key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      if (ctl.insert && at_tail) begin
        id <= key;
      end else if (ctl.remove && found && hit_out) begin
        id <= nbr_id;
      end
    end
  end

endmodule

// ===== src/fifo_queue_with_remove_by_id.sv =====
// Ordered process-id queue with insert at tail, remove by id and clear.
// A request is latched with every cell's match, then resolved in the update state;
// no new request is accepted until that update commits. The update resolves the
// first match along the cell chain, shifts the tail side left and loads the
// response register. A stalled response holds the update state.
// Reset: synchronous; clears the entry count and control, slot ids are not reset.
module fifo_queue_with_remove_by_id import fqr_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic       clk,
  input  logic       rst,
  fqr_req_if.sink    in_ch,
  fqr_rsp_if.source  out_ch
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [OP_BITS-1:0] op;
  logic [ID_BITS-1:0] key;
  logic [ID_BITS-1:0] key_sel;
  logic               accept, commit;
  logic               is_ins, is_rem, is_clr, full, found;
  logic [ST_BITS-1:0] status_next;
  logic [ID_BITS-1:0] head_next;
  cell_ctl_t          ctl;

  logic               rsp_valid;
  logic [ST_BITS-1:0] rsp_status;
  logic [CNT_BITS-1:0] rsp_count;
  logic               rsp_empty;
  logic [PID_BITS-1:0] rsp_head;

  logic [ID_BITS-1:0] cell_id [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] hit_chain;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign commit      = (state == S_UPDATE) && (!rsp_valid || out_ch.ready);

  // capture compares against the incoming id, commit uses the latched one
  assign key_sel = accept ? ID_BITS'(in_ch.process_id) : key;

  assign is_ins = (op == OP_INSERT);
  assign is_rem = (op == OP_REMOVE);
  assign is_clr = (op == OP_CLEAR);
  assign full   = (count == CW'(QUEUE_DEPTH));
  assign found  = hit_chain[QUEUE_DEPTH-1];

  assign ctl.capture = accept;
  assign ctl.commit  = commit;
  assign ctl.insert  = is_ins;
  assign ctl.remove  = is_rem;

  genvar k;
  generate
    for (k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      logic               hit_in;
      logic [ID_BITS-1:0] nbr_id;
      if (k == 0) begin : g_first
        assign hit_in = 1'b0;
      end else begin : g_mid
        assign hit_in = hit_chain[k-1];
      end
      if (k == QUEUE_DEPTH - 1) begin : g_last
        assign nbr_id = '0;
      end else begin : g_inner
        assign nbr_id = cell_id[k+1];
      end
      fqr_cell #(.ID_BITS(ID_BITS)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .key      (key_sel),
        .occupied (CW'(k) < count),
        .at_tail  (CW'(k) == count),
        .found    (found),
        .nbr_id   (nbr_id),
        .hit_in   (hit_in),
        .hit_out  (hit_chain[k]),
        .id       (cell_id[k])
      );
    end
  endgenerate

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    if (is_ins) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else if (is_rem) begin
      if (count == '0) begin
        status_next = ST_EMPTY;
      end else if (!found) begin
        status_next = ST_NOT_FOUND;
      end else begin
        count_next = count - 1'b1;
      end
    end else if (is_clr) begin
      count_next = '0;
    end
  end

  // head after the update, read from cells 0 and 1 before they change, or the key on an insert into an empty queue
  always_comb begin
    if (count_next == '0) begin
      head_next = '0;
    end else if (is_ins && count == '0) begin
      head_next = key;
    end else if (is_rem && found && hit_chain[0]) begin
      head_next = cell_id[1];
    end else begin
      head_next = cell_id[0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_UPDATE;
      S_UPDATE: if (commit) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (out_ch.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= in_ch.opcode;
      key <= ID_BITS'(in_ch.process_id);
    end
    if (commit) begin
      rsp_status <= status_next;
      rsp_count  <= CNT_BITS'(count_next);
      rsp_empty  <= (count_next == '0);
      rsp_head   <= PID_BITS'(head_next);
    end
  end

  assign out_ch.valid       = rsp_valid;
  assign out_ch.status      = rsp_status;
  assign out_ch.entry_count = rsp_count;
  assign out_ch.queue_empty = rsp_empty;
  assign out_ch.head_id     = rsp_head;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_accept_then_update: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_UPDATE))
    else $error("request not followed by update cycle");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    commit && is_ins && !full |=> count == CW'($past(count) + 1'b1))
    else $error("insert did not grow the queue");

  a_commit_resp: assert property (@(posedge clk) disable iff (rst)
    commit |=> rsp_valid && (state == S_IDLE))
    else $error("update did not produce a response");

endmodule

// ===== verif/fifo_queue_with_remove_by_id_tb.sv =====
// Self-checking testbench for the process-id queue with remove by id.
`timescale 1ns / 1ps

module fifo_queue_with_remove_by_id_tb;
  import fqr_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int HOLD_AT     = 400;  // responses seen before the long receiver hold
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_WAIT  = 20;

  // opcode value with no operation assigned; the queue is left unchanged
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_BITS-1:0]  opcode;
    logic [PID_BITS-1:0] pid;
  } pid_req_t;

  typedef struct packed {
    logic [ST_BITS-1:0]  status;
    logic [CNT_BITS-1:0] entry_count;
    logic                queue_empty;
    logic [PID_BITS-1:0] head_id;
  } pid_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fqr_req_if req_ch();
  fqr_rsp_if rsp_ch();

  fifo_queue_with_remove_by_id #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS(ID_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(req_ch),
    .out_ch(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pid_req_t           pending_reqs[$];
  pid_rsp_t           expected_rsp[$];
  logic [ID_BITS-1:0] shadow_ids[$];  // predicted queue contents, head first
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 mismatch_count = 0;
  int                 rsp_seen = 0;
  int                 hold_left = 0;
  logic               hold_done = 1'b0;

  // Apply one request to the shadow queue and return the response it gives.
  function automatic pid_rsp_t queue_apply(pid_req_t req);
    pid_rsp_t           rsp;
    logic [ID_BITS-1:0] key;
    int                 pos;
    key = req.pid[ID_BITS-1:0];
    rsp.status = ST_OK;
    case (req.opcode)
      OP_INSERT: begin
        if (shadow_ids.size() >= QUEUE_DEPTH) rsp.status = ST_FULL;
        else shadow_ids.push_back(key);
      end
      OP_REMOVE: begin
        if (shadow_ids.size() == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          pos = -1;
          for (int i = 0; i < shadow_ids.size(); i++) begin
            if (pos < 0 && shadow_ids[i] == key) pos = i;
          end
          if (pos < 0) rsp.status = ST_NOT_FOUND;
          else shadow_ids.delete(pos);
        end
      end
      OP_CLEAR: shadow_ids.delete();
      default: ;  // unused opcode leaves the queue alone
    endcase
    rsp.entry_count = CNT_BITS'(shadow_ids.size());
    rsp.queue_empty = (shadow_ids.size() == 0);
    rsp.head_id = (shadow_ids.size() == 0) ? '0 : PID_BITS'(shadow_ids[0]);
    return rsp;
  endfunction

  // Request driver: holds a request until taken, predicts on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        expected_rsp.push_back(queue_apply(pending_reqs.pop_front()));
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_ch.valid      <= 1'b1;
          req_ch.opcode     <= pending_reqs[0].opcode;
          req_ch.process_id <= pending_reqs[0].pid;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response ready, with one long hold to back the queue up.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && rsp_seen >= HOLD_AT) begin
      rsp_ch.ready <= 1'b0;
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic note_mismatch(string what, int exp_val, int act_val);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what,
               exp_val, act_val);
  endtask

  // Response monitor.
  always @(posedge clk) begin
    pid_rsp_t exp_rsp;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      rsp_seen <= rsp_seen + 1;
      if (expected_rsp.size() == 0) begin
        note_mismatch("unexpected response status", -1, int'(rsp_ch.status));
      end else begin
        exp_rsp = expected_rsp.pop_front();
        if (rsp_ch.status !== exp_rsp.status)
          note_mismatch("status", int'(exp_rsp.status), int'(rsp_ch.status));
        if (rsp_ch.entry_count !== exp_rsp.entry_count)
          note_mismatch("entry_count", int'(exp_rsp.entry_count),
                        int'(rsp_ch.entry_count));
        if (rsp_ch.queue_empty !== exp_rsp.queue_empty)
          note_mismatch("queue_empty", int'(exp_rsp.queue_empty),
                        int'(rsp_ch.queue_empty));
        if (rsp_ch.head_id !== exp_rsp.head_id)
          note_mismatch("head_id", int'(exp_rsp.head_id), int'(rsp_ch.head_id));
      end
    end
  end

  task automatic add_req(logic [OP_BITS-1:0] op, logic [PID_BITS-1:0] pid);
    pid_req_t req;
    req.opcode = op;
    req.pid    = pid;
    pending_reqs.push_back(req);
  endtask

  // Random request; fill mode leans toward inserts so the queue reaches full.
  task automatic add_random_req(logic fill_mode);
    int                  pick;
    logic [PID_BITS-1:0] pid;
    logic [OP_BITS-1:0]  op;
    pick = $urandom_range(99);
    // mostly a small id pool so removes find their targets and duplicates occur
    pid = ($urandom_range(99) < 75) ? PID_BITS'($urandom_range(15)) : PID_BITS'($urandom);
    if (pick < 4) op = OP_CLEAR;
    else if (pick < 8) op = OP_UNUSED;
    else if (pick < (fill_mode ? 72 : 35)) op = OP_INSERT;
    else op = OP_REMOVE;
    add_req(op, pid);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || expected_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) add_random_req(((i / 40) % 2) == 0);
    wait_drained();
  endtask

  initial begin
    req_ch.valid      = 1'b0;
    req_ch.opcode     = OP_INSERT;
    req_ch.process_id = '0;
    rsp_ch.ready      = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty-queue cases, extremes, duplicates, full, clear
    add_req(OP_REMOVE, 8'h00);
    add_req(OP_CLEAR, 8'hff);
    add_req(OP_UNUSED, 8'hff);
    add_req(OP_INSERT, 8'h00);
    add_req(OP_INSERT, 8'hff);
    add_req(OP_INSERT, 8'haa);
    add_req(OP_INSERT, 8'h55);
    add_req(OP_INSERT, 8'haa);
    add_req(OP_REMOVE, 8'haa);
    add_req(OP_REMOVE, 8'h12);
    add_req(OP_UNUSED, 8'h00);
    for (int i = 0; i < 12; i++) add_req(OP_INSERT, PID_BITS'(8'h10 + i));
    add_req(OP_INSERT, 8'h77);
    add_req(OP_REMOVE, 8'h00);
    add_req(OP_REMOVE, 8'h1b);
    add_req(OP_CLEAR, 8'h00);
    wait_drained();

    send_idle_pct = 38;
    recv_idle_pct = 46;
    run_random(170);
    send_idle_pct = 46;
    recv_idle_pct = 38;
    run_random(170);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(160);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_rsp.size() == 0) begin
      $display("[fifo_queue_with_remove_by_id] OK");
    end else begin
      $display("[fifo_queue_with_remove_by_id] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[fifo_queue_with_remove_by_id] ERROR");
    $finish;
  end

endmodule
